// ----- design/ihpv_pkg.sv -----
// Shared types and constants for the bracketed IPv6 host validator.
`timescale 1ns / 1ps
`default_nettype none

package ihpv_pkg;

  // Character codes that the scanner looks for.
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  // Port value limits: a valid port lies strictly between these.
  localparam logic [15:0] PORT_MAX = 16'hFFFF;
  localparam logic [15:0] PORT_MIN = 16'd1;
  localparam logic [19:0] PORT_MAX_WIDE = 20'h0FFFF;
  localparam logic [19:0] DEC_RADIX = 20'd10;

  // Scan phase of the current string.
  typedef enum logic [2:0] {
    PH_OPEN  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CLOSE = 3'd2,
    PH_PORT  = 3'd3,
    PH_FAIL  = 3'd4
  } phase_e;

  // Everything the scanner remembers between characters.
  typedef struct packed {
    phase_e      phase;
    logic        seen_colon;
    logic        prev_was_colon;
    logic        double_colon_seen;
    logic [15:0] port_value;
    logic        port_has_digit;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:             PH_OPEN,
    seen_colon:        1'b0,
    prev_was_colon:    1'b0,
    double_colon_seen: 1'b0,
    port_value:        16'd0,
    port_has_digit:    1'b0
  };

endpackage

`default_nettype wire

// ----- design/ihpv_step.sv -----
// Next-state and verdict logic for one character of the host string.
`timescale 1ns / 1ps
`default_nettype none

module ihpv_step import ihpv_pkg::*; (
  input  scan_state_t state_i,
  input  logic [7:0]  ch_i,
  output scan_state_t state_o,
  output logic        verdict_o
);

  logic        is_digit;
  logic        is_hex;
  logic [19:0] port_acc;

  // Character classes.
  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign is_hex   = is_digit || ((ch_i >= CH_LO_A) && (ch_i <= CH_LO_F)) ||
                    ((ch_i >= CH_UP_A) && (ch_i <= CH_UP_F));

  // Decimal accumulation of the port, one digit per character.
  assign port_acc = ({4'd0, state_i.port_value} * DEC_RADIX) + {16'd0, ch_i[3:0]};

  // State update for the current character.
  always_comb begin
    state_o = state_i;
    case (state_i.phase)
      PH_OPEN: begin
        state_o.phase = (ch_i == CH_LBRACK) ? PH_ADDR : PH_FAIL;
      end
      PH_ADDR: begin
        if (ch_i == CH_RBRACK) begin
          state_o.phase = PH_CLOSE;
        end else if (ch_i == CH_COLON) begin
          if (state_i.prev_was_colon) begin
            if (state_i.double_colon_seen) begin
              state_o.phase = PH_FAIL;
            end
            state_o.double_colon_seen = 1'b1;
          end
          state_o.seen_colon     = 1'b1;
          state_o.prev_was_colon = 1'b1;
        end else if (is_hex) begin
          state_o.prev_was_colon = 1'b0;
        end else begin
          state_o.phase = PH_FAIL;
        end
      end
      PH_CLOSE: begin
        state_o.phase = (ch_i == CH_COLON) ? PH_PORT : PH_FAIL;
      end
      PH_PORT: begin
        if (is_digit) begin
          state_o.port_value     = (port_acc > PORT_MAX_WIDE) ? PORT_MAX : port_acc[15:0];
          state_o.port_has_digit = 1'b1;
        end else begin
          state_o.phase = PH_FAIL;
        end
      end
      default: begin
        state_o.phase = PH_FAIL;
      end
    endcase
  end

  // Verdict on the state left after this character.
  always_comb begin
    case (state_o.phase)
      PH_CLOSE: verdict_o = state_o.seen_colon;
      PH_PORT:  verdict_o = state_o.seen_colon && state_o.port_has_digit &&
                            (state_o.port_value > PORT_MIN) &&
                            (state_o.port_value < PORT_MAX);
      default:  verdict_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/ihpv_out_reg.sv -----
// Result register holding one verdict until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module ihpv_out_reg (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  logic ok_i,
  output logic ready_o,
  output logic valid_o,
  output logic ok_o,
  input  logic ready_i
);

  logic valid_q;
  logic valid_d;
  logic ok_q;

  // The register is free when empty or being emptied this cycle.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads on a new item only.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ok_q <= ok_i;
    end
  end

  assign valid_o = valid_q;
  assign ok_o    = ok_q;

endmodule

`default_nettype wire

// ----- design/ipv6_host_port_validator.sv -----
// Top level of the bracketed IPv6 host and port validator.
//
//   Channel | Signals                          | Direction | Item
//   --------+----------------------------------+-----------+-------------------------
//   in      | in_valid_i, in_ready_o, ch_i,    | input     | one character of the
//           | last_i                           |           | host string
//   out     | out_valid_o, out_ready_i,        | output    | one verdict per string
//           | host_ok_o                        |           |
//
// Each character waits in the input register and is scanned by
// ihpv_step on its way out; the verdict of a last character lands in the
// result register at the edge that empties the input register, so a verdict
// is offered from the result register, where it waits until it is taken.
// One character is taken every cycle while no last character waits on a full result.
// Reset clears the scan state and both valid flags. A stalled result holds
// only a last character in the input register; other characters keep flowing.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_host_port_validator import ihpv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       host_ok_o
);

  logic        s1_valid_q;
  logic        s1_valid_d;
  logic [7:0]  ch_q;
  logic        last_q;
  logic        s1_go;
  logic        res_ready;
  logic        verdict;
  scan_state_t state_q;
  scan_state_t state_d;
  scan_state_t state_next;

  // The input register drains unless a verdict is blocked by a full result.
  assign s1_go      = s1_valid_q && (!last_q || res_ready);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign s1_valid_d = (in_valid_i && in_ready_o) || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  // Scan logic for the held character.
  ihpv_step u_step (
    .state_i   (state_q),
    .ch_i      (ch_q),
    .state_o   (state_next),
    .verdict_o (verdict)
  );

  // Scan state advances per character and clears after the last one.
  always_comb begin
    state_d = state_q;
    if (s1_go) begin
      state_d = last_q ? SCAN_RESET : state_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCAN_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register.
  ihpv_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q && last_q),
    .ok_i    (verdict),
    .ready_o (res_ready),
    .valid_o (out_valid_o),
    .ok_o    (host_ok_o),
    .ready_i (out_ready_i)
  );

  // A string's last character returns the scanner to its starting state.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && last_q) |=> (state_q == SCAN_RESET))
    else $error("scan state not cleared after last item");

  // A held character is neither lost nor altered.
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(ch_q) && $stable(last_q)))
    else $error("input register changed while held");

  // A verdict appears only after a last character has left the input register.
  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_go && last_q))
    else $error("verdict without a last item");

  // The port accumulator stays at zero until the first port digit.
  a_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!state_q.port_has_digit) |-> (state_q.port_value == 16'd0))
    else $error("port value set without a digit");

endmodule

`default_nettype wire
